[rtl/core/bfds_pkg.sv]
// Shared widths, types and register codes for the back-to-front depth sort.
package bfds_pkg;

    localparam int COORD_W      = 16;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int SQ_W         = 2 * DIFF_W - 1;
    localparam int KEY_W        = 34;
    localparam int IDX_W        = 6;
    localparam int MAX_RESULTS  = 64;
    localparam int CNT_W        = $clog2(MAX_RESULTS + 1);
    localparam int MAX_PRIMS_DEF = 64;

    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_EYE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EYE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EYE_Z = 2'd2;

    // one stored primitive
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [IDX_W-1:0] idx;
    } t_entry;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic   load;
        logic   drain;
        t_entry item;
    } t_cell_ctl;

endpackage

[rtl/core/bfds_dist.sv]
// Three-stage squared eye distance pipeline: difference, square, sum.
module bfds_dist (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic signed [bfds_pkg::COORD_W-1:0] i_eye_x,
    input  logic signed [bfds_pkg::COORD_W-1:0] i_eye_y,
    input  logic signed [bfds_pkg::COORD_W-1:0] i_eye_z,
    input  logic                                i_valid,
    input  logic signed [bfds_pkg::COORD_W-1:0] i_vertex_x,
    input  logic signed [bfds_pkg::COORD_W-1:0] i_vertex_y,
    input  logic signed [bfds_pkg::COORD_W-1:0] i_vertex_z,
    input  logic                                i_final,
    output logic                                o_valid,
    output logic                                o_final,
    output logic [bfds_pkg::KEY_W-1:0]          o_key
);
    import bfds_pkg::*;

    logic                     r_v1, r_v2, r_v3;
    logic                     r_f1, r_f2, r_f3;
    logic signed [DIFF_W-1:0] r_dx, r_dy, r_dz;
    logic [SQ_W-1:0]          r_sx, r_sy, r_sz;
    logic [KEY_W-1:0]         r_key;

    logic signed [DIFF_W-1:0]  n_dx, n_dy, n_dz;
    logic signed [2*DIFF_W-1:0] w_px, w_py, w_pz;
    logic [KEY_W:0]            n_sum;

    assign n_dx = {i_eye_x[COORD_W-1], i_eye_x} - {i_vertex_x[COORD_W-1], i_vertex_x};
    assign n_dy = {i_eye_y[COORD_W-1], i_eye_y} - {i_vertex_y[COORD_W-1], i_vertex_y};
    assign n_dz = {i_eye_z[COORD_W-1], i_eye_z} - {i_vertex_z[COORD_W-1], i_vertex_z};

    assign w_px = r_dx * r_dx;
    assign w_py = r_dy * r_dy;
    assign w_pz = r_dz * r_dz;

    // squares are non-negative and below 2^33, so the sum fits the key width
    assign n_sum = (KEY_W+1)'(r_sx) + (KEY_W+1)'(r_sy) + (KEY_W+1)'(r_sz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1  <= i_final;
        r_dx  <= n_dx;
        r_dy  <= n_dy;
        r_dz  <= n_dz;
        r_f2  <= r_f1;
        r_sx  <= w_px[SQ_W-1:0];
        r_sy  <= w_py[SQ_W-1:0];
        r_sz  <= w_pz[SQ_W-1:0];
        r_f3  <= r_f2;
        r_key <= n_sum[KEY_W-1:0];
    end

    assign o_valid = r_v3;
    assign o_final = r_f3;
    assign o_key   = r_key;

endmodule

[rtl/core/bfds_cell.sv]
// One cell of the insertion chain: holds one entry, kept in descending key order.
module bfds_cell (
    input  logic                i_clk,
    input  bfds_pkg::t_cell_ctl i_ctl,
    input  logic                i_occupied,
    input  logic                i_prev_ins,
    input  bfds_pkg::t_entry    i_prev,
    input  bfds_pkg::t_entry    i_next,
    output logic                o_ins,
    output bfds_pkg::t_entry    o_entry
);
    import bfds_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // strict compare: a tie stays behind the older entry
    assign o_ins = !i_occupied || (i_ctl.item.key > r_entry.key);

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.drain) begin
            n_entry = i_next;
        end else if (i_ctl.load && o_ins) begin
            n_entry = i_prev_ins ? i_prev : i_ctl.item;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

[rtl/core/back_to_front_depth_sort.sv]
// Top level: eye registers, distance pipeline, insertion cell chain and drain control.
//
//  channel  | handshake            | beat contents
//  ---------+----------------------+---------------------------------------------------
//  input    | start & !busy        | i_vertex_x/y/z, i_final_item
//  result   | o_valid (strobe)     | o_sorted_index, o_distance_sq, o_run_end, o_overflow
//  config   | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// Loading takes one item per cycle while busy is low; each item passes the distance
// pipeline (difference, square, sum registers) into the cell chain. A final item holds
// busy until its run has left: the pipeline, the insertion, then one result per cycle
// from the head cell, min(stored, 64) in all. Reset clears control and eye registers
// only; cells are undefined until loaded. Results cannot be held off by the receiver.
module back_to_front_depth_sort #(
    parameter int MAX_PRIMS = bfds_pkg::MAX_PRIMS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [bfds_pkg::COORD_W-1:0]  i_vertex_x,
    input  logic signed [bfds_pkg::COORD_W-1:0]  i_vertex_y,
    input  logic signed [bfds_pkg::COORD_W-1:0]  i_vertex_z,
    input  logic                                 i_final_item,
    output logic                                 o_valid,
    output logic [bfds_pkg::IDX_W-1:0]           o_sorted_index,
    output logic [bfds_pkg::KEY_W-1:0]           o_distance_sq,
    output logic                                 o_run_end,
    output logic                                 o_overflow,
    input  logic                                 i_cfg_we,
    input  logic [bfds_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bfds_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import bfds_pkg::*;

    localparam int FILL_W = $clog2(MAX_PRIMS + 1);

    logic signed [COORD_W-1:0] r_eye_x, r_eye_y, r_eye_z;
    logic                      r_busy;
    logic                      r_drain;
    logic [CNT_W-1:0]          r_left;
    logic                      r_ovf;
    logic [FILL_W-1:0]         r_fill;
    logic                      r_dropped;

    logic                      w_accept;
    logic                      w_key_valid, w_key_final;
    logic [KEY_W-1:0]          w_key;
    logic                      w_full;
    logic [FILL_W-1:0]         w_fill_after;
    logic                      w_drop_after;
    logic [CNT_W-1:0]          w_run_len;
    t_cell_ctl                 w_ctl;
    t_entry                    w_entry [MAX_PRIMS];
    logic                      w_ins   [MAX_PRIMS];

    assign w_accept = start && !r_busy;
    assign busy     = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eye_x <= '0;
            r_eye_y <= '0;
            r_eye_z <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_EYE_X: r_eye_x <= i_cfg_data;
                CFG_EYE_Y: r_eye_y <= i_cfg_data;
                CFG_EYE_Z: r_eye_z <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    bfds_dist u_dist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_eye_x    (r_eye_x),
        .i_eye_y    (r_eye_y),
        .i_eye_z    (r_eye_z),
        .i_valid    (w_accept),
        .i_vertex_x (i_vertex_x),
        .i_vertex_y (i_vertex_y),
        .i_vertex_z (i_vertex_z),
        .i_final    (i_final_item),
        .o_valid    (w_key_valid),
        .o_final    (w_key_final),
        .o_key      (w_key)
    );

    assign w_full       = (r_fill == FILL_W'(MAX_PRIMS));
    assign w_fill_after = w_full ? r_fill : r_fill + FILL_W'(1);
    assign w_drop_after = r_dropped || w_full;
    assign w_run_len    = (int'(w_fill_after) > MAX_RESULTS) ? CNT_W'(MAX_RESULTS)
                                                             : CNT_W'(w_fill_after);

    always_comb begin
        w_ctl.load     = w_key_valid && !w_full;
        w_ctl.drain    = r_drain;
        w_ctl.item.key = w_key;
        w_ctl.item.idx = IDX_W'(r_fill);
    end

    for (genvar i = 0; i < MAX_PRIMS; i++) begin : g_cell
        logic   w_prev_ins;
        t_entry w_prev;
        t_entry w_next;

        if (i == 0) begin : g_head
            assign w_prev_ins = 1'b0;
            assign w_prev     = '0;
        end else begin : g_body
            assign w_prev_ins = w_ins[i-1];
            assign w_prev     = w_entry[i-1];
        end

        if (i == MAX_PRIMS - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_entry[i+1];
        end

        bfds_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_occupied (r_fill > FILL_W'(i)),
            .i_prev_ins (w_prev_ins),
            .i_prev     (w_prev),
            .i_next     (w_next),
            .o_ins      (w_ins[i]),
            .o_entry    (w_entry[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_drain   <= 1'b0;
            r_left    <= '0;
            r_ovf     <= 1'b0;
            r_fill    <= '0;
            r_dropped <= 1'b0;
        end else begin
            if (w_accept && i_final_item) begin
                r_busy <= 1'b1;
            end
            if (w_key_valid) begin
                r_fill    <= w_fill_after;
                r_dropped <= w_drop_after;
                if (w_key_final) begin
                    r_drain <= 1'b1;
                    r_left  <= w_run_len;
                    r_ovf   <= w_drop_after;
                end
            end
            if (r_drain) begin
                r_left <= r_left - CNT_W'(1);
                // last beat of the run: the set is closed
                if (r_left == CNT_W'(1)) begin
                    r_drain   <= 1'b0;
                    r_busy    <= 1'b0;
                    r_fill    <= '0;
                    r_dropped <= 1'b0;
                end
            end
        end
    end

    assign o_valid        = r_drain;
    assign o_sorted_index = w_entry[0].idx;
    assign o_distance_sq  = w_entry[0].key;
    assign o_run_end      = r_drain && (r_left == CNT_W'(1));
    assign o_overflow     = r_ovf;

endmodule

[tb/back_to_front_depth_sort_test.sv]
// Self-checking testbench for the back-to-front depth sort: predicted draw order vs DUT.
module back_to_front_depth_sort_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bfds_pkg::*;

    localparam int DEPTH       = MAX_PRIMS_DEF;
    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      closes_set;
    } t_vertex_beat;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [KEY_W-1:0] dist_sq;
        logic             run_end;
        logic             overflow;
    } t_draw_beat;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic signed [COORD_W-1:0] i_vertex_x = '0;
    logic signed [COORD_W-1:0] i_vertex_y = '0;
    logic signed [COORD_W-1:0] i_vertex_z = '0;
    logic                      i_final_item = 1'b0;
    logic                      o_valid;
    logic [IDX_W-1:0]          o_sorted_index;
    logic [KEY_W-1:0]          o_distance_sq;
    logic                      o_run_end;
    logic                      o_overflow;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_idx = CFG_EYE_X;
    logic [CFG_DATA_W-1:0]     i_cfg_data = '0;

    // predictor state
    logic signed [COORD_W-1:0] view_x = '0;
    logic signed [COORD_W-1:0] view_y = '0;
    logic signed [COORD_W-1:0] view_z = '0;
    t_entry                    depth_list[$];
    logic                      set_dropped = 1'b0;
    t_draw_beat                draw_order_q[$];

    t_vertex_beat              vertex_q[$];
    t_vertex_beat              cur_beat;
    t_vertex_beat              prev_vertex = '0;
    int                        items_queued = 0;
    int                        items_taken = 0;
    int                        gap_pct = 0;
    int                        errors = 0;
    int                        quiet_cycles = 0;

    back_to_front_depth_sort u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_vertex_x     (i_vertex_x),
        .i_vertex_y     (i_vertex_y),
        .i_vertex_z     (i_vertex_z),
        .i_final_item   (i_final_item),
        .o_valid        (o_valid),
        .o_sorted_index (o_sorted_index),
        .o_distance_sq  (o_distance_sq),
        .o_run_end      (o_run_end),
        .o_overflow     (o_overflow),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [KEY_W-1:0] eye_dist_sq(input logic signed [COORD_W-1:0] vx,
                                                     input logic signed [COORD_W-1:0] vy,
                                                     input logic signed [COORD_W-1:0] vz);
        longint dx;
        longint dy;
        longint dz;
        dx = longint'(view_x) - longint'(vx);
        dy = longint'(view_y) - longint'(vy);
        dz = longint'(view_z) - longint'(vz);
        return KEY_W'(dx * dx + dy * dy + dz * dz);
    endfunction

    // insertion keeps farthest first; equal keys stay in load order
    task automatic load_vertex(input t_vertex_beat b);
        t_entry     e;
        t_draw_beat r;
        int         pos;
        e.key = eye_dist_sq(b.x, b.y, b.z);
        e.idx = IDX_W'(depth_list.size());
        if (depth_list.size() < DEPTH) begin
            pos = 0;
            while (pos < depth_list.size() && depth_list[pos].key >= e.key)
                pos++;
            depth_list.insert(pos, e);
        end else begin
            set_dropped = 1'b1;
        end
        if (b.closes_set) begin
            foreach (depth_list[k]) begin
                if (k < MAX_RESULTS) begin
                    r.idx      = depth_list[k].idx;
                    r.dist_sq  = depth_list[k].key;
                    r.run_end  = (k == depth_list.size() - 1) || (k == MAX_RESULTS - 1);
                    r.overflow = set_dropped;
                    draw_order_q = {draw_order_q, r};
                end
            end
            depth_list.delete();
            set_dropped = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input logic [KEY_W-1:0] want,
                               input logic [KEY_W-1:0] got);
        if (got !== want) begin
            $display("%0t %s: expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // driver: holds a beat while busy, otherwise picks the next one or idles
    always @(posedge i_clk) begin : drive_vertices
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                load_vertex(cur_beat);
                items_taken <= items_taken + 1;
            end
            if (!start || !busy) begin
                if (vertex_q.size() > 0 && $urandom_range(99) >= gap_pct) begin
                    cur_beat = vertex_q.pop_front();
                    start        <= 1'b1;
                    i_vertex_x   <= cur_beat.x;
                    i_vertex_y   <= cur_beat.y;
                    i_vertex_z   <= cur_beat.z;
                    i_final_item <= cur_beat.closes_set;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watch_results
        t_draw_beat want;
        if (i_rst_n && o_valid) begin
            if (draw_order_q.size() == 0) begin
                $display("%0t unexpected result beat: index %0d, distance %0d",
                         $time, o_sorted_index, o_distance_sq);
                errors++;
            end else begin
                want = draw_order_q.pop_front();
                check_field("sorted_index", KEY_W'(want.idx), KEY_W'(o_sorted_index));
                check_field("distance_sq", want.dist_sq, o_distance_sq);
                check_field("run_end", KEY_W'(want.run_end), KEY_W'(o_run_end));
                check_field("overflow", KEY_W'(want.overflow), KEY_W'(o_overflow));
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (start && !busy) || o_valid || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("back_to_front_depth_sort: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_beat(input logic signed [COORD_W-1:0] vx,
                              input logic signed [COORD_W-1:0] vy,
                              input logic signed [COORD_W-1:0] vz, input logic fin);
        t_vertex_beat b;
        b.x = vx;
        b.y = vy;
        b.z = vz;
        b.closes_set = fin;
        vertex_q = {vertex_q, b};
        items_queued++;
    endtask

    // mostly random vertices, some close to the eye, some repeats for exact ties
    task automatic queue_set(input int len);
        t_vertex_beat v;
        int           mode;
        for (int i = 0; i < len; i++) begin
            mode = $urandom_range(9);
            if (mode < 5) begin
                v.x = COORD_W'($urandom);
                v.y = COORD_W'($urandom);
                v.z = COORD_W'($urandom);
            end else if (mode < 8) begin
                v.x = COORD_W'(view_x + $urandom_range(127) - 64);
                v.y = COORD_W'(view_y + $urandom_range(127) - 64);
                v.z = COORD_W'(view_z + $urandom_range(127) - 64);
            end else begin
                v = prev_vertex;
            end
            prev_vertex = v;
            queue_beat(v.x, v.y, v.z, i == len - 1);
        end
    endtask

    task automatic set_eye(input logic [CFG_DATA_W-1:0] ex, input logic [CFG_DATA_W-1:0] ey,
                           input logic [CFG_DATA_W-1:0] ez);
        logic [CFG_IDX_W-1:0]  reg_sel[3];
        logic [CFG_DATA_W-1:0] reg_val[3];
        reg_sel = '{CFG_EYE_X, CFG_EYE_Y, CFG_EYE_Z};
        reg_val = '{ex, ey, ez};
        for (int i = 0; i < 3; i++) begin
            @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= reg_sel[i];
            i_cfg_data <= reg_val[i];
            case (reg_sel[i])
                CFG_EYE_X: view_x = reg_val[i];
                CFG_EYE_Y: view_y = reg_val[i];
                CFG_EYE_Z: view_z = reg_val[i];
                default: ;
            endcase
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait for every beat to go in, every result to come out, then let the pipe drain
    task automatic settle();
        while (items_taken != items_queued)
            @(posedge i_clk);
        while (draw_order_q.size() != 0 || busy)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int phase_start;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // eye at its reset value, the origin
        queue_beat(-32768, -32768, -32768, 1'b1);
        queue_beat(32767, 32767, 32767, 1'b0);
        queue_beat(0, 0, 0, 1'b0);
        queue_beat(1, 0, 0, 1'b0);
        queue_beat(-1, 0, 0, 1'b0);
        queue_beat(0, 1, 0, 1'b0);
        queue_beat(0, 0, -1, 1'b0);
        queue_beat(-32768, 0, 0, 1'b0);
        queue_beat(0, -32768, 0, 1'b0);
        queue_beat(0, 0, 32767, 1'b0);
        queue_beat(0, 0, 0, 1'b1);
        settle();

        // eye in a corner: largest possible distance, and a vertex on the eye
        set_eye(16'h8000, 16'h7fff, 16'h8000);
        queue_beat(32767, -32768, 32767, 1'b0);
        queue_beat(-32768, 32767, -32768, 1'b0);
        queue_beat(-32768, -32768, -32768, 1'b0);
        queue_beat(32767, 32767, 32767, 1'b0);
        queue_beat(-32768, 32767, -32768, 1'b0);
        queue_beat(32767, -32768, 32767, 1'b1);
        settle();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    set_eye(16'h7fff, 16'h8000, 16'h7fff);
                    gap_pct = 45;
                end
                1: begin
                    set_eye(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                            CFG_DATA_W'($urandom));
                    gap_pct = 0;
                end
                2: begin
                    set_eye(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                            CFG_DATA_W'($urandom));
                    gap_pct = 22;
                end
                default: begin
                    set_eye(16'h0000, CFG_DATA_W'($urandom), 16'h8000);
                    gap_pct = 45;
                end
            endcase
            phase_start = items_queued;
            // store full: drops before the final beat, and the final beat itself dropped
            if (ph == 3)
                queue_set(DEPTH + 3);
            while (items_queued - phase_start < 12 + ((ph == 3) ? DEPTH + 3 : 0))
                queue_set($urandom_range(1, 12));
            settle();
        end

        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("back_to_front_depth_sort: match");
        end else begin
            $display("back_to_front_depth_sort: mismatch");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/bfds_pkg.sv
rtl/core/bfds_dist.sv
rtl/core/bfds_cell.sv
rtl/core/back_to_front_depth_sort.sv
tb/back_to_front_depth_sort_test.sv
